// File: sv/psct_pkg.sv
// Shared types, widths and the periodic image offset table for the collision time unit.
`default_nettype none

package psct_pkg;

    // Image count and fixed field widths
    localparam int NUM_IMAGES_DEF = 27;
    localparam int COORD_W        = 32;
    localparam int IDX_W          = 5;
    localparam int CFG_IDX_W      = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

    // Box length after reset: 10.0 in Q16.16
    localparam logic [COORD_W-1:0] BOX_RESET = 32'd655360;

    // Arithmetic unit widths
    localparam int MUL_W  = 68;   // operand width of the shared multiplier
    localparam int SQ_W   = 134;  // discriminant width
    localparam int DEN_W  = 68;   // divisor width
    localparam int QUO_W  = 32;   // quotient width
    localparam int FRAC_W = 16;   // fraction bits of the time

    // Offset codes: two bit two's complement of -1, 0, +1
    typedef logic [1:0] off_t;
    localparam off_t OFF_ZERO = 2'b00;
    localparam off_t OFF_POS  = 2'b01;
    localparam off_t OFF_NEG  = 2'b11;

    typedef struct packed {
        off_t x;
        off_t y;
        off_t z;
    } offset_t;

    // Input request payload
    typedef struct packed {
        logic        [COORD_W-1:0] pos_a_x;
        logic        [COORD_W-1:0] pos_a_y;
        logic        [COORD_W-1:0] pos_a_z;
        logic signed [COORD_W-1:0] vel_a_x;
        logic signed [COORD_W-1:0] vel_a_y;
        logic signed [COORD_W-1:0] vel_a_z;
        logic        [COORD_W-1:0] pos_b_x;
        logic        [COORD_W-1:0] pos_b_y;
        logic        [COORD_W-1:0] pos_b_z;
        logic signed [COORD_W-1:0] vel_b_x;
        logic signed [COORD_W-1:0] vel_b_y;
        logic signed [COORD_W-1:0] vel_b_z;
    } in_item_t;

    // Result request payload
    typedef struct packed {
        logic               has_collision;
        logic [COORD_W-1:0] time_to_collision;
        logic [IDX_W-1:0]   image_index;
    } out_item_t;

    // Offset of each periodic image of the second sphere, in scan order
    function automatic offset_t image_offset(input logic [IDX_W-1:0] k);
        offset_t o;
        case (k)
            5'd0:    o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
            5'd1:    o = '{OFF_POS,  OFF_ZERO, OFF_ZERO};
            5'd2:    o = '{OFF_ZERO, OFF_POS,  OFF_ZERO};
            5'd3:    o = '{OFF_ZERO, OFF_ZERO, OFF_POS };
            5'd4:    o = '{OFF_NEG,  OFF_ZERO, OFF_ZERO};
            5'd5:    o = '{OFF_ZERO, OFF_NEG,  OFF_ZERO};
            5'd6:    o = '{OFF_ZERO, OFF_ZERO, OFF_NEG };
            5'd7:    o = '{OFF_ZERO, OFF_POS,  OFF_POS };
            5'd8:    o = '{OFF_POS,  OFF_ZERO, OFF_POS };
            5'd9:    o = '{OFF_POS,  OFF_POS,  OFF_ZERO};
            5'd10:   o = '{OFF_ZERO, OFF_POS,  OFF_NEG };
            5'd11:   o = '{OFF_NEG,  OFF_ZERO, OFF_POS };
            5'd12:   o = '{OFF_POS,  OFF_NEG,  OFF_ZERO};
            5'd13:   o = '{OFF_ZERO, OFF_NEG,  OFF_POS };
            5'd14:   o = '{OFF_POS,  OFF_ZERO, OFF_NEG };
            5'd15:   o = '{OFF_NEG,  OFF_POS,  OFF_ZERO};
            5'd16:   o = '{OFF_ZERO, OFF_NEG,  OFF_NEG };
            5'd17:   o = '{OFF_NEG,  OFF_ZERO, OFF_NEG };
            5'd18:   o = '{OFF_NEG,  OFF_NEG,  OFF_ZERO};
            5'd19:   o = '{OFF_POS,  OFF_POS,  OFF_POS };
            5'd20:   o = '{OFF_NEG,  OFF_POS,  OFF_POS };
            5'd21:   o = '{OFF_POS,  OFF_NEG,  OFF_POS };
            5'd22:   o = '{OFF_POS,  OFF_POS,  OFF_NEG };
            5'd23:   o = '{OFF_POS,  OFF_NEG,  OFF_NEG };
            5'd24:   o = '{OFF_NEG,  OFF_POS,  OFF_NEG };
            5'd25:   o = '{OFF_NEG,  OFF_NEG,  OFF_POS };
            5'd26:   o = '{OFF_NEG,  OFF_NEG,  OFF_NEG };
            default: o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// File: sv/psct_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module psct_mul #(
    parameter int W = psct_pkg::MUL_W
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic                done,
    output logic [2*W-1:0]      prod
);

    localparam int CNT_W = $clog2(W + 1);

    logic [2*W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       sum;

    // Add the multiplicand on a set low bit, then shift the product right
    always_comb
    begin
        sum       = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, a} : '0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = {{W{1'b0}}, b};
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance the partial product
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// File: sv/psct_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle, rounded down.
`default_nettype none

module psct_sqrt #(
    parameter int NW = psct_pkg::SQ_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NW-1:0]     n,
    output logic                   done,
    output logic [NW/2-1:0]        root
);

    localparam int RW    = NW / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [NW-1:0]    n_reg, n_next;
    logic [RW:0]      rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RW+2:0]    rem_sh;
    logic [RW+2:0]    trial;
    logic [RW+2:0]    diff;
    logic             fits;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg, n_reg[NW-1:NW-2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        fits      = rem_sh >= trial;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = n;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next    = {n_reg[NW-3:0], 2'b00};
            rem_next  = fits ? diff[RW:0] : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance radicand, remainder and root
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: sv/psct_div.sv
// Restoring divider for the time quotient, one quotient bit per cycle, saturating.
`default_nettype none

module psct_div #(
    parameter int DW = psct_pkg::DEN_W,
    parameter int QW = psct_pkg::QUO_W,
    parameter int FW = psct_pkg::FRAC_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] c,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [QW-1:0]      quot
);

    // Dividend is c scaled by 2^FW; its top part sits above the quotient bits
    localparam int SH    = QW - FW;
    localparam int HI_W  = DW - SH;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [QW-1:0]    lo_reg, lo_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             fits;
    logic             sat;

    // Bring down one dividend bit and subtract the divisor where it fits
    always_comb
    begin
        rem_sh    = {rem_reg, lo_reg[QW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        fits      = rem_sh >= {1'b0, den_reg};
        sat       = {{SH{1'b0}}, c[DW-1:SH]} >= den;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next = den;
            if (sat)
            begin
                // Quotient does not fit: saturate at once
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {{SH{1'b0}}, c[DW-1:SH]};
                lo_next   = {c[SH-1:0], {FW{1'b0}}};
                q_next    = '0;
                cnt_next  = CNT_W'(QW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
            lo_next  = {lo_reg[QW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance remainder, dividend bits and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// File: sv/periodic_sphere_collision_time_unit.sv
// Top level: sequencer over periodic images around a shared bit-serial multiplier, root and divider.
`default_nettype none

// Takes one pair of unit-radius spheres and returns the earliest strictly positive
// contact time over NUM_IMAGES periodic images of the second sphere, with the image
// index (earliest-listed image wins ties; time saturates at all ones). One request is
// worked at a time; in_stall is high from acceptance until the result is loaded into
// the output register, and the next request can be taken while that result waits.
// The sequencer runs every product through the single 68-bit bit-serial multiplier, one
// bit per cycle: first the relative speed squared, then per image the approach and
// distance products. An image rejected by the approach or contact test ends there; one
// that passes goes on through the second-order products and, unless its discriminant is
// negative, the 67-step square root and the 32-step division. Box lengths are written on
// the cfg port; a write to an index past box_len_z is ignored.
module periodic_sphere_collision_time_unit #(
    parameter int NUM_IMAGES = psct_pkg::NUM_IMAGES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire psct_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output psct_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic [psct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [psct_pkg::COORD_W-1:0]        cfg_data
);

    localparam int CW = psct_pkg::COORD_W;
    localparam int IW = psct_pkg::IDX_W;
    localparam int MW = psct_pkg::MUL_W;
    localparam int SW = psct_pkg::SQ_W;
    localparam int RW = psct_pkg::SQ_W / 2;
    localparam int DW = psct_pkg::DEN_W;
    localparam int QW = psct_pkg::QUO_W;
    localparam int VW = CW + 1;          // relative velocity magnitude
    localparam int PW = CW + 3;          // signed separation
    localparam int AW = CW + 2;          // separation magnitude
    localparam int VVW = 2 * CW + 2;     // speed squared
    localparam int HW = 2 * CW + 6;      // signed approach term
    localparam int HMW = 2 * CW + 3;     // approach magnitude
    localparam int RRW = 2 * CW + 4;     // distance squared

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Squared contact distance (2.0)^2 in units of 2^-32
    localparam logic [RRW-1:0] CONTACT = RRW'(1) << 34;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_ROOT  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [4:0] {
        OP_VV = 5'b00001,
        OP_HV = 5'b00010,
        OP_RR = 5'b00100,
        OP_BB = 5'b01000,
        OP_AC = 5'b10000
    } op_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [1:0]           axis_reg, axis_next;
    logic [IW-1:0]        img_reg, img_next;
    logic                 mul_start_reg, mul_start_next;
    logic                 sqrt_start_reg, sqrt_start_next;
    logic                 div_start_reg, div_start_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        box_x_reg, box_y_reg, box_z_reg;

    psct_pkg::in_item_t   item_reg, item_next;
    psct_pkg::out_item_t  out_reg, out_next;
    logic [VW-1:0]        vmag_reg [3];
    logic [VW-1:0]        vmag_next [3];
    logic [2:0]           vneg_reg, vneg_next;
    logic [VVW-1:0]       vv_reg, vv_next;
    logic [HW-1:0]        h_reg, h_next;
    logic [RRW-1:0]       rr_reg, rr_next;
    logic [HMW-1:0]       hm_reg, hm_next;
    logic [RRW-1:0]       c_reg, c_next;
    logic [SW-1:0]        bb_reg, bb_next;
    logic [QW-1:0]        best_t_reg, best_t_next;
    logic [IW-1:0]        best_k_reg, best_k_next;

    logic [VW-1:0]        vrel_w [3];
    logic [CW-1:0]        pa_sel, pb_sel, box_sel;
    psct_pkg::off_t       off_sel;
    psct_pkg::offset_t    offs;
    logic [PW-1:0]        r_base, r_val;
    logic [AW-1:0]        rmag;
    logic                 rneg;
    logic [VW-1:0]        vmag_sel;
    logic                 vneg_sel;
    logic [MW-1:0]        mul_a, mul_b;
    logic                 mul_done;
    logic [2*MW-1:0]      mul_prod;
    logic [SW-1:0]        disc;
    logic                 sqrt_done;
    logic [RW-1:0]        sqrt_root;
    logic [DW-1:0]        den;
    logic                 div_done;
    logic [QW-1:0]        div_q;
    logic [HW-1:0]        h_prod;
    logic [HW-1:0]        h_neg;
    logic                 accept;

    assign accept = in_valid && !in_stall;

    // Relative velocity of the incoming request, as magnitude and sign
    always_comb
    begin
        vrel_w[0] = {in_data.vel_b_x[CW-1], in_data.vel_b_x}
                  - {in_data.vel_a_x[CW-1], in_data.vel_a_x};
        vrel_w[1] = {in_data.vel_b_y[CW-1], in_data.vel_b_y}
                  - {in_data.vel_a_y[CW-1], in_data.vel_a_y};
        vrel_w[2] = {in_data.vel_b_z[CW-1], in_data.vel_b_z}
                  - {in_data.vel_a_z[CW-1], in_data.vel_a_z};
    end

    // Separation along the current axis for the current image
    always_comb
    begin
        offs = psct_pkg::image_offset(img_reg);
        case (axis_reg)
            AXIS_X:
            begin
                pa_sel  = item_reg.pos_a_x;
                pb_sel  = item_reg.pos_b_x;
                box_sel = box_x_reg;
                off_sel = offs.x;
            end
            AXIS_Y:
            begin
                pa_sel  = item_reg.pos_a_y;
                pb_sel  = item_reg.pos_b_y;
                box_sel = box_y_reg;
                off_sel = offs.y;
            end
            default:
            begin
                pa_sel  = item_reg.pos_a_z;
                pb_sel  = item_reg.pos_b_z;
                box_sel = box_z_reg;
                off_sel = offs.z;
            end
        endcase
        r_base = {3'b000, pb_sel} - {3'b000, pa_sel};
        case (off_sel)
            psct_pkg::OFF_POS: r_val = r_base + {3'b000, box_sel};
            psct_pkg::OFF_NEG: r_val = r_base - {3'b000, box_sel};
            default:           r_val = r_base;
        endcase
        rneg     = r_val[PW-1];
        rmag     = rneg ? AW'(PW'(0) - r_val) : r_val[AW-1:0];
        vmag_sel = vmag_reg[axis_reg];
        vneg_sel = vneg_reg[axis_reg];
    end

    // Select multiplier operands for the current product
    always_comb
    begin
        case (op_reg)
            OP_VV:
            begin
                mul_a = {{(MW-VW){1'b0}}, vmag_sel};
                mul_b = {{(MW-VW){1'b0}}, vmag_sel};
            end
            OP_HV:
            begin
                mul_a = {{(MW-AW){1'b0}}, rmag};
                mul_b = {{(MW-VW){1'b0}}, vmag_sel};
            end
            OP_RR:
            begin
                mul_a = {{(MW-AW){1'b0}}, rmag};
                mul_b = {{(MW-AW){1'b0}}, rmag};
            end
            OP_BB:
            begin
                mul_a = {{(MW-HMW){1'b0}}, hm_reg};
                mul_b = {{(MW-HMW){1'b0}}, hm_reg};
            end
            OP_AC:
            begin
                mul_a = {{(MW-VVW){1'b0}}, vv_reg};
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign disc   = bb_reg - mul_prod[SW-1:0];
    assign den    = {1'b0, hm_reg} + {1'b0, sqrt_root};
    assign h_prod = {{(HW-(2*CW+3)){1'b0}}, mul_prod[2*CW+2:0]};
    assign h_neg  = HW'(0) - h_reg;

    psct_mul #(.W(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    psct_sqrt #(.NW(SW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .n     (disc),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    psct_div #(.DW(DW), .QW(QW), .FW(psct_pkg::FRAC_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .c     (c_reg),
        .den   (den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Sequence the products, root and division over the images
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        axis_next       = axis_reg;
        img_next        = img_reg;
        mul_start_next  = 1'b0;
        sqrt_start_next = 1'b0;
        div_start_next  = 1'b0;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        item_next       = item_reg;
        out_next        = out_reg;
        vmag_next       = vmag_reg;
        vneg_next       = vneg_reg;
        vv_next         = vv_reg;
        h_next          = h_reg;
        rr_next         = rr_reg;
        hm_next         = hm_reg;
        c_next          = c_reg;
        bb_next         = bb_reg;
        best_t_next     = best_t_reg;
        best_k_next     = best_k_reg;

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    for (int i = 0; i < 3; i++)
                    begin
                        vneg_next[i] = vrel_w[i][VW-1];
                        vmag_next[i] = vrel_w[i][VW-1] ? VW'(0) - vrel_w[i] : vrel_w[i];
                    end
                    vv_next        = '0;
                    found_next     = 1'b0;
                    img_next       = '0;
                    axis_next      = AXIS_X;
                    op_next        = OP_VV;
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_VV:
                        begin
                            vv_next = vv_reg + mul_prod[VVW-1:0];
                            if (axis_reg == AXIS_Z)
                            begin
                                axis_next = AXIS_X;
                                h_next    = '0;
                                rr_next   = '0;
                                op_next   = OP_HV;
                            end
                            else
                            begin
                                axis_next = axis_reg + 1'b1;
                            end
                            mul_start_next = 1'b1;
                        end
                        OP_HV:
                        begin
                            h_next         = (rneg ^ vneg_sel) ? h_reg - h_prod
                                                               : h_reg + h_prod;
                            op_next        = OP_RR;
                            mul_start_next = 1'b1;
                        end
                        OP_RR:
                        begin
                            rr_next = rr_reg + mul_prod[RRW-1:0];
                            if (axis_reg == AXIS_Z)
                            begin
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                axis_next      = axis_reg + 1'b1;
                                op_next        = OP_HV;
                                mul_start_next = 1'b1;
                            end
                        end
                        OP_BB:
                        begin
                            bb_next        = mul_prod[SW-1:0];
                            op_next        = OP_AC;
                            mul_start_next = 1'b1;
                        end
                        OP_AC:
                        begin
                            // Negative discriminant: no contact for this image
                            if (mul_prod[SW-1:0] > bb_reg)
                            begin
                                state_next = S_NEXT;
                            end
                            else
                            begin
                                sqrt_start_next = 1'b1;
                                state_next      = S_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_NEXT;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                // Keep only approaching, non-overlapping images
                if (h_reg[HW-1] && (rr_reg > CONTACT))
                begin
                    hm_next        = h_neg[HMW-1:0];
                    c_next         = rr_reg - CONTACT;
                    op_next        = OP_BB;
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!found_reg || (div_q < best_t_reg))
                    begin
                        found_next  = 1'b1;
                        best_t_next = div_q;
                        best_k_next = img_reg;
                    end
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (img_reg == IW'(NUM_IMAGES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    img_next       = img_reg + 1'b1;
                    axis_next      = AXIS_X;
                    h_next         = '0;
                    rr_next        = '0;
                    op_next        = OP_HV;
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.has_collision     = found_reg;
                    out_next.time_to_collision = found_reg ? best_t_reg : '0;
                    out_next.image_index       = found_reg ? best_k_reg : '0;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_VV;
            axis_reg       <= AXIS_X;
            img_reg        <= '0;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            box_x_reg      <= psct_pkg::BOX_RESET;
            box_y_reg      <= psct_pkg::BOX_RESET;
            box_z_reg      <= psct_pkg::BOX_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            axis_reg       <= axis_next;
            img_reg        <= img_next;
            mul_start_reg  <= mul_start_next;
            sqrt_start_reg <= sqrt_start_next;
            div_start_reg  <= div_start_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    psct_pkg::CFG_BOX_X: box_x_reg <= cfg_data;
                    psct_pkg::CFG_BOX_Y: box_y_reg <= cfg_data;
                    psct_pkg::CFG_BOX_Z: box_z_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        out_reg    <= out_next;
        vmag_reg   <= vmag_next;
        vneg_reg   <= vneg_next;
        vv_reg     <= vv_next;
        h_reg      <= h_next;
        rr_reg     <= rr_next;
        hm_reg     <= hm_next;
        c_reg      <= c_next;
        bb_reg     <= bb_next;
        best_t_reg <= best_t_next;
        best_k_reg <= best_k_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Each unit finishes only while the sequencer waits on it
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MUL)
        else $error("multiplier finished outside the product wait");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == S_ROOT)
        else $error("square root finished outside its wait");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait");

    // Image counter stays within the configured image count
    a_img_range: assert property (@(posedge clk) disable iff (!rst_n)
        img_reg < IW'(NUM_IMAGES))
        else $error("image index past the image count");

    // Best image was seen no later than the current one
    a_best_order: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> best_k_reg <= img_reg)
        else $error("best image index ahead of scan");

    // Contact test runs only after all three axes are summed
    a_check_axis: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> axis_reg == AXIS_Z)
        else $error("contact test before last axis");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the periodic sphere collision time unit.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int IW = psct_pkg::IDX_W;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    psct_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    psct_pkg::out_item_t out_data;
    logic cfg_we;
    logic [psct_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [psct_pkg::COORD_W-1:0] cfg_data;

    // Offsets of the second sphere's images, in scan order
    int img_off [27][3] = '{
        '{ 0, 0, 0},
        '{ 1, 0, 0}, '{ 0, 1, 0}, '{ 0, 0, 1}, '{-1, 0, 0}, '{ 0,-1, 0}, '{ 0, 0,-1},
        '{ 0, 1, 1}, '{ 1, 0, 1}, '{ 1, 1, 0}, '{ 0, 1,-1}, '{-1, 0, 1}, '{ 1,-1, 0},
        '{ 0,-1, 1}, '{ 1, 0,-1}, '{-1, 1, 0}, '{ 0,-1,-1}, '{-1, 0,-1}, '{-1,-1, 0},
        '{ 1, 1, 1}, '{-1, 1, 1}, '{ 1,-1, 1}, '{ 1, 1,-1}, '{ 1,-1,-1}, '{-1, 1,-1},
        '{-1,-1, 1}, '{-1,-1,-1}
    };

    logic [31:0] box_len [3];
    psct_pkg::in_item_t pending_pairs [$];
    psct_pkg::out_item_t expected_hits [$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int quiet_cycles;

    periodic_sphere_collision_time_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [159:0] magnitude(longint x);
        longint m;
        m = (x < 0) ? -x : x;
        return {96'd0, m[63:0]};
    endfunction

    // Integer square root, rounded down
    function automatic logic [159:0] floor_sqrt(logic [159:0] n);
        logic [159:0] res;
        logic [159:0] bitv;
        res = '0;
        bitv = 160'd1 << 158;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Earliest positive contact time over all images
    function automatic psct_pkg::out_item_t collision_time(psct_pkg::in_item_t it);
        longint pa [3];
        longint pb [3];
        longint vr [3];
        longint r;
        logic [159:0] vv, hp, hn, rr, mr, prod, hm, c, bb, ac, den, num;
        logic [31:0] t;
        logic [31:0] best_t;
        int best_k;
        bit found;
        psct_pkg::out_item_t res;
        pa[0] = longint'(it.pos_a_x);
        pa[1] = longint'(it.pos_a_y);
        pa[2] = longint'(it.pos_a_z);
        pb[0] = longint'(it.pos_b_x);
        pb[1] = longint'(it.pos_b_y);
        pb[2] = longint'(it.pos_b_z);
        vr[0] = longint'(it.vel_b_x) - longint'(it.vel_a_x);
        vr[1] = longint'(it.vel_b_y) - longint'(it.vel_a_y);
        vr[2] = longint'(it.vel_b_z) - longint'(it.vel_a_z);
        vv = '0;
        for (int l = 0; l < 3; l++)
            vv = vv + magnitude(vr[l]) * magnitude(vr[l]);
        found = 0;
        best_t = '0;
        best_k = 0;
        for (int k = 0; k < 27; k++)
        begin
            hp = '0;
            hn = '0;
            rr = '0;
            for (int l = 0; l < 3; l++)
            begin
                r = pb[l] + longint'(img_off[k][l]) * longint'(box_len[l]) - pa[l];
                mr = magnitude(r);
                prod = mr * magnitude(vr[l]);
                if ((r < 0) != (vr[l] < 0))
                    hn = hn + prod;
                else
                    hp = hp + prod;
                rr = rr + mr * mr;
            end
            if (hn > hp && rr > (160'd1 << 34))
            begin
                hm = hn - hp;
                c = rr - (160'd1 << 34);
                bb = hm * hm;
                ac = vv * c;
                if (ac <= bb)
                begin
                    den = hm + floor_sqrt(bb - ac);
                    num = c << 16;
                    if (den == 0 || num >= (den << 32))
                        t = '1;
                    else
                        t = 32'(num / den);
                    if (!found || t < best_t)
                    begin
                        found = 1;
                        best_t = t;
                        best_k = k;
                    end
                end
            end
        end
        res.has_collision = found;
        res.time_to_collision = found ? best_t : '0;
        res.image_index = found ? IW'(best_k) : '0;
        return res;
    endfunction

    // Queue one request for the driver
    task automatic add_pair(psct_pkg::in_item_t it);
        pending_pairs = {pending_pairs, it};
    endtask

    // Feed requests, hold a stalled one, record the prediction at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_hits = {expected_hits, collision_time(in_data)};
                void'(pending_pairs.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_pairs[0];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check results and stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        psct_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (out_data.has_collision !== want.has_collision
                        || out_data.time_to_collision !== want.time_to_collision
                        || out_data.image_index !== want.image_index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %h %0d, got %0d %h %0d",
                                want.has_collision, want.time_to_collision, want.image_index,
                                out_data.has_collision, out_data.time_to_collision,
                                out_data.image_index);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz);
        logic [31:0] vals [3];
        vals[0] = lx;
        vals[1] = ly;
        vals[2] = lz;
        for (int i = 0; i < 3; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= (i == 0) ? psct_pkg::CFG_BOX_X
                       : (i == 1) ? psct_pkg::CFG_BOX_Y : psct_pkg::CFG_BOX_Z;
            cfg_data <= vals[i];
            box_len[i] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every request is through and every result is back
    task automatic drain;
        while (pending_pairs.size() > 0 || expected_hits.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic psct_pkg::in_item_t make_pair(logic [31:0] pax, logic [31:0] pbx,
                                                      logic [31:0] vax, logic [31:0] vbx);
        psct_pkg::in_item_t it;
        it = '0;
        it.pos_a_x = pax;
        it.pos_b_x = pbx;
        it.vel_a_x = vax;
        it.vel_b_x = vbx;
        return it;
    endfunction

    // Mostly approaching neighbors, some pure noise
    function automatic psct_pkg::in_item_t random_pair();
        psct_pkg::in_item_t it;
        logic [31:0] pa [3];
        logic [31:0] pb [3];
        logic [31:0] va [3];
        logic [31:0] vb [3];
        int d;
        int shift;
        int step;
        if ($urandom_range(3) == 0)
        begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return it;
        end
        shift = $urandom_range(12);
        for (int l = 0; l < 3; l++)
        begin
            pa[l] = $urandom_range(32'h0014_0000);
            d = int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            step = d >>> shift;
            pb[l] = pa[l] + d;
            va[l] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            vb[l] = va[l] - step + ($urandom_range(32'h0000_4000) - 32'h0000_2000);
        end
        it = {pa[0], pa[1], pa[2], va[0], va[1], va[2],
              pb[0], pb[1], pb[2], vb[0], vb[1], vb[2]};
        return it;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 15;
        recv_idle_pct = 71;
        box_len[0] = psct_pkg::BOX_RESET;
        box_len[1] = psct_pkg::BOX_RESET;
        box_len[2] = psct_pkg::BOX_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases on the reset box
        add_pair(make_pair(32'd0, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000));
        add_pair(make_pair(32'd0, 32'h0004_0000, 32'd0, 32'hFFFF_0000));
        add_pair(make_pair(32'd0, 32'h0002_0001, 32'd0, 32'hC000_0000));
        add_pair(make_pair(32'd0, 32'h0003_0000, 32'd0, 32'hFFFF_FFFF));
        add_pair(make_pair(32'd0, 32'h0001_0000, 32'd0, 32'hFFFF_0000));
        add_pair(make_pair(32'd0, 32'h0002_0000, 32'd0, 32'hFFFF_0000));
        add_pair(make_pair(32'h0004_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        add_pair(make_pair(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000));
        add_pair('1);
        add_pair('0);
        begin
            psct_pkg::in_item_t miss;
            miss = make_pair(32'd0, 32'h0004_0000, 32'd0, 32'hFFFF_0000);
            miss.pos_b_y = 32'h0005_0000;
            add_pair(miss);
            miss = make_pair(32'h0009_0000, 32'h0001_0000, 32'd0, 32'h0001_0000);
            add_pair(miss);
        end
        drain();

        // Coinciding images: zero box
        write_box(32'd0, 32'd0, 32'd0);
        add_pair(make_pair(32'd0, 32'h0004_0000, 32'd0, 32'hFFFF_0000));
        for (int i = 0; i < 40; i++)
            add_pair(random_pair());
        drain();

        // Largest box, other idling pattern
        send_idle_pct = 71;
        recv_idle_pct = 15;
        write_box('1, '1, '1);
        for (int i = 0; i < 40; i++)
            add_pair(random_pair());
        drain();

        // Random box sizes
        write_box($urandom_range(32'h0014_0000, 32'h0003_0000),
                  $urandom_range(32'h0014_0000, 32'h0003_0000),
                  $urandom_range(32'h0014_0000, 32'h0003_0000));
        for (int i = 0; i < 200; i++)
            add_pair(random_pair());
        drain();

        // Small box, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_box(32'h0004_0000, 32'h0005_0000, 32'h0006_0000);
        for (int i = 0; i < 200; i++)
            add_pair(random_pair());
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
